@@ rtl/srdm_pkg.sv @@
// Package for the sorted record delta merge: payload structs, the step entry
// passed from the front to the back, the queue sizes, and the codes the modules share.
// No dependencies.
package srdm_pkg;

    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] REQ_BASE     = 2'd0;
    localparam logic [1:0] REQ_CHANGE   = 2'd1;
    localparam logic [1:0] REQ_END_BASE = 2'd2;
    localparam logic [1:0] REQ_END_CHG  = 2'd3;

    localparam logic [1:0] KIND_RECORD = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] NEED_BASE   = 2'd0;
    localparam logic [1:0] NEED_CHANGE = 2'd1;
    localparam logic [1:0] NEED_BOTH   = 2'd2;
    localparam logic [1:0] NEED_DONE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRICT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_COUNTS = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [31:0]        pre_id;
        logic [31:0]        post_id;
        logic signed [15:0] weight;
        logic [31:0]        hit_count;
    } req_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        out_pre;
        logic [31:0]        out_post;
        logic signed [15:0] out_weight;
        logic [1:0]         need;
        logic [31:0]        total;
        logic               last;
    } rsp_t;

    typedef struct packed {
        logic        is_err;
        logic        has_rec;
        logic [31:0] pre;
        logic [31:0] post;
        logic [15:0] weight;
        logic [1:0]  need;
        logic [31:0] total;
    } step_t;

endpackage

@@ rtl/srdm_front.sv @@
// Front part of the merge: holds the configuration, the two stream heads and
// the running total, and classifies each accepted transaction into one step
// entry. Depends on srdm_pkg.
module srdm_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [srdm_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [srdm_pkg::CFG_DATA_W-1:0]  wr_data,
    input  logic                             take,
    input  srdm_pkg::req_t                   req,
    output srdm_pkg::step_t                  step
);
    import srdm_pkg::*;

    logic [31:0] min_count_reg;
    logic        strict_reg;
    logic        use_counts_reg;

    logic        bv_reg, cv_reg, be_reg, ce_reg, err_reg;
    logic [63:0] bkey_reg, ckey_reg;
    logic [15:0] bw_reg, cw_reg;
    logic [31:0] bcnt_reg, total_reg;

    logic        bv_next, cv_next, be_next, ce_next, err_next;
    logic [63:0] bkey_next, ckey_next;
    logic [15:0] bw_next, cw_next;
    logic [31:0] bcnt_next, total_next;

    logic [63:0] in_key;
    logic        go, base_less, base_more, emit;
    logic [63:0] ekey;
    logic [15:0] ew, neg_cnt;
    logic        nb, nc;

    assign in_key  = {req.post_id, req.pre_id};
    assign neg_cnt = (~bcnt_next[15:0]) + 16'd1;

    always_comb
    begin
        bv_next    = bv_reg;
        cv_next    = cv_reg;
        be_next    = be_reg;
        ce_next    = ce_reg;
        err_next   = err_reg;
        bkey_next  = bkey_reg;
        ckey_next  = ckey_reg;
        bw_next    = bw_reg;
        cw_next    = cw_reg;
        bcnt_next  = bcnt_reg;
        emit       = 1'b0;
        ekey       = '0;
        ew         = '0;
        go         = 1'b0;
        base_less  = 1'b0;
        base_more  = 1'b0;
        if (!err_reg)
        begin
            unique case (req.req_type)
                REQ_BASE:
                begin
                    if (!(bv_reg || be_reg))
                    begin
                        bkey_next = in_key;
                        bw_next   = req.weight;
                        bcnt_next = req.hit_count;
                        bv_next   = 1'b1;
                    end
                end
                REQ_CHANGE:
                begin
                    if (!(cv_reg || ce_reg))
                    begin
                        ckey_next = in_key;
                        cw_next   = req.weight;
                        cv_next   = 1'b1;
                    end
                end
                REQ_END_BASE:
                begin
                    if (!bv_reg)
                        be_next = 1'b1;
                end
                REQ_END_CHG:
                begin
                    if (!cv_reg)
                        ce_next = 1'b1;
                end
                default:
                begin
                end
            endcase

            go        = (bv_next || be_next) && (cv_next || ce_next) && (bv_next || cv_next);
            base_less = !cv_next || (bv_next && (bkey_next < ckey_next));
            base_more = !bv_next || (cv_next && (bkey_next > ckey_next));

            if (go && base_less)
            begin
                bv_next = 1'b0;
                ekey    = bkey_next;
                ew      = bw_next;
                emit    = 1'b1;
                if (use_counts_reg)
                begin
                    if (bcnt_next < min_count_reg)
                        emit = 1'b0;
                    else if (bw_next[15])
                        ew = neg_cnt;
                    else
                        ew = bcnt_next[15:0];
                end
            end
            else if (go)
            begin
                if (base_more && strict_reg && (cw_next == 16'd0))
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    cv_next = 1'b0;
                    if (!base_more)
                        bv_next = 1'b0;
                    if (cw_next != 16'd0)
                    begin
                        ekey = ckey_next;
                        ew   = cw_next;
                        emit = 1'b1;
                    end
                end
            end
        end

        total_next = total_reg;
        if (emit && (total_reg != '1))
            total_next = total_reg + 32'd1;

        nb = !(bv_next || be_next);
        nc = !(cv_next || ce_next);

        step.is_err  = err_next;
        step.has_rec = emit;
        step.pre     = ekey[31:0];
        step.post    = ekey[63:32];
        step.weight  = ew;
        step.total   = total_next;
        if (err_next)
            step.need = NEED_DONE;
        else if (nb && nc)
            step.need = NEED_BOTH;
        else if (nb)
            step.need = NEED_BASE;
        else if (nc)
            step.need = NEED_CHANGE;
        else
            step.need = NEED_DONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_count_reg  <= '0;
            strict_reg     <= 1'b0;
            use_counts_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_MIN_COUNT:  min_count_reg  <= wr_data;
                CFG_STRICT:     strict_reg     <= wr_data[0];
                CFG_USE_COUNTS: use_counts_reg <= wr_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bv_reg    <= 1'b0;
            cv_reg    <= 1'b0;
            be_reg    <= 1'b0;
            ce_reg    <= 1'b0;
            err_reg   <= 1'b0;
            total_reg <= '0;
        end
        else if (take)
        begin
            bv_reg    <= bv_next;
            cv_reg    <= cv_next;
            be_reg    <= be_next;
            ce_reg    <= ce_next;
            err_reg   <= err_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            bkey_reg <= bkey_next;
            ckey_reg <= ckey_next;
            bw_reg   <= bw_next;
            cw_reg   <= cw_next;
            bcnt_reg <= bcnt_next;
        end
    end

    // Once raised, the error state holds until reset.
    assert property (@(posedge clk) disable iff (!rst_n) err_reg |=> err_reg)
        else $error("error state cleared without reset");

    // A step never emits a record while in the error state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && step.is_err) |-> !step.has_rec)
        else $error("record emitted in an error step");

    // The running total changes only after an accepted transaction, by at most one record.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(take) |-> $stable(total_reg))
        else $error("total changed without a transaction");

endmodule

@@ rtl/srdm_queue.sv @@
// Short queue of step entries between the front and the back part of the
// merge, held in registers. Depends on srdm_pkg.
module srdm_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  srdm_pkg::step_t  push_data,
    input  logic             pop,
    output srdm_pkg::step_t  head,
    output logic             not_empty,
    output logic             not_full
);
    import srdm_pkg::*;

    step_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    assign not_empty = (count_reg != '0);
    assign not_full  = (count_reg != QCNT_W'(QDEPTH));
    assign head      = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    // Entries are never written into a full queue or taken from an empty one.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> not_full)
        else $error("push into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
        else $error("pop from an empty queue");

endmodule

@@ rtl/srdm_back.sv @@
// Back part of the merge: turns each queued step entry into its record item, if it has
// one, and its status or error item on the output channel. Depends on srdm_pkg.
module srdm_back (
    input  logic             clk,
    input  logic             rst_n,
    input  srdm_pkg::step_t  head,
    input  logic             head_valid,
    output logic             pop,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output srdm_pkg::rsp_t   rsp
);
    import srdm_pkg::*;

    logic phase_reg;
    logic rec_now;

    assign rec_now   = head.has_rec && !phase_reg;
    assign rsp_valid = head_valid;
    assign pop       = head_valid && rsp_ready && !rec_now;

    always_comb
    begin
        if (rec_now)
        begin
            rsp.kind       = KIND_RECORD;
            rsp.out_pre    = head.pre;
            rsp.out_post   = head.post;
            rsp.out_weight = head.weight;
            rsp.need       = NEED_BASE;
            rsp.total      = '0;
            rsp.last       = 1'b0;
        end
        else
        begin
            rsp.kind       = head.is_err ? KIND_ERROR : KIND_STATUS;
            rsp.out_pre    = '0;
            rsp.out_post   = '0;
            rsp.out_weight = '0;
            rsp.need       = head.need;
            rsp.total      = head.total;
            rsp.last       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= 1'b0;
        else if (head_valid && rsp_ready)
            phase_reg <= rec_now;
    end

endmodule

@@ rtl/sorted_record_delta_merge.sv @@
// Two-way merge of a sorted base stream and a sorted change stream.
// Throughput: one input transaction per cycle while the queue is not full; the output
// carries one item per cycle while rsp_ready is high. Each step entry is registered in
// a four-entry queue; a step with a record sends the record item, then its status item.
// Reset clears the heads, end flags, total, error state, configuration and queue.
module sorted_record_delta_merge (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [srdm_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [srdm_pkg::CFG_DATA_W-1:0]  wr_data,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  srdm_pkg::req_t                   req,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output srdm_pkg::rsp_t                   rsp
);
    import srdm_pkg::*;

    step_t step, head;
    logic  take, pop, not_empty, not_full;

    assign req_ready = not_full;
    assign take      = req_valid && not_full;

    srdm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .take     (take),
        .req      (req),
        .step     (step)
    );

    srdm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push_data (step),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .not_full  (not_full)
    );

    srdm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (not_empty),
        .pop        (pop),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp)
    );

endmodule

@@ tb/sv/tb_sorted_record_delta_merge.sv @@
// Self-checking testbench for sorted_record_delta_merge: drives base and change record
// streams, predicts every merged record, status and error item, and checks each result.
// Depends on srdm_pkg and sorted_record_delta_merge only.
module tb_sorted_record_delta_merge;

    timeunit 1ns;
    timeprecision 1ps;

    import srdm_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  wr_index  = '0;
    logic [CFG_DATA_W-1:0] wr_data   = '0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_t                  req       = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    rsp_t                  rsp;

    // Merge predictor state.
    logic [63:0] bh_key      = '0;
    logic [15:0] bh_w        = '0;
    logic [31:0] bh_cnt      = '0;
    logic [63:0] ch_key      = '0;
    logic [15:0] ch_w        = '0;
    logic        bh_valid    = 1'b0;
    logic        ch_valid    = 1'b0;
    logic        base_done   = 1'b0;
    logic        chg_done    = 1'b0;
    logic        err_latched = 1'b0;
    logic [31:0] rec_total   = '0;

    logic [31:0] cfg_min_count  = '0;
    logic        cfg_strict     = 1'b0;
    logic        cfg_use_counts = 1'b0;

    rsp_t        expected_rsp[$];
    logic [63:0] base_cursor = '0;
    logic [63:0] chg_cursor  = '0;

    int err_count    = 0;
    int gap_pct      = 0;
    int stall_pct    = 0;
    int rsp_hold_len = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    sorted_record_delta_merge DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic rsp_t error_rsp();
        rsp_t e;
        e       = '0;
        e.kind  = KIND_ERROR;
        e.need  = NEED_DONE;
        e.total = rec_total;
        e.last  = 1'b1;
        return e;
    endfunction

    function automatic void merge_step(req_t r);
        rsp_t        rec;
        rsp_t        st;
        logic [63:0] key;
        logic [31:0] neg_cnt;
        logic        emit;
        logic        need_b;
        logic        need_c;
        int          c;
        key  = {r.post_id, r.pre_id};
        rec  = '0;
        st   = '0;
        emit = 1'b0;
        c    = 0;
        if (err_latched)
        begin
            expected_rsp.push_back(error_rsp());
            return;
        end
        case (r.req_type)
            REQ_BASE:
                if (!bh_valid && !base_done)
                begin
                    bh_key   = key;
                    bh_w     = r.weight;
                    bh_cnt   = r.hit_count;
                    bh_valid = 1'b1;
                end
            REQ_CHANGE:
                if (!ch_valid && !chg_done)
                begin
                    ch_key   = key;
                    ch_w     = r.weight;
                    ch_valid = 1'b1;
                end
            REQ_END_BASE:
                if (!bh_valid)
                    base_done = 1'b1;
            default:
                if (!ch_valid)
                    chg_done = 1'b1;
        endcase
        if ((bh_valid || base_done) && (ch_valid || chg_done) && (bh_valid || ch_valid))
        begin
            if (!bh_valid)
                c = 1;
            else if (!ch_valid)
                c = -1;
            else
                c = (bh_key < ch_key) ? -1 : ((bh_key > ch_key) ? 1 : 0);
            if (c < 0)
            begin
                bh_valid       = 1'b0;
                rec.out_pre    = bh_key[31:0];
                rec.out_post   = bh_key[63:32];
                rec.out_weight = bh_w;
                emit           = 1'b1;
                if (cfg_use_counts)
                begin
                    neg_cnt = 32'd0 - bh_cnt;
                    if (bh_cnt < cfg_min_count)
                        emit = 1'b0;
                    else if (bh_w[15])
                        rec.out_weight = neg_cnt[15:0];
                    else
                        rec.out_weight = bh_cnt[15:0];
                end
            end
            else
            begin
                if (c > 0 && cfg_strict && ch_w == 16'd0)
                begin
                    err_latched = 1'b1;
                    expected_rsp.push_back(error_rsp());
                    return;
                end
                ch_valid = 1'b0;
                if (c == 0)
                    bh_valid = 1'b0;
                if (ch_w != 16'd0)
                begin
                    rec.out_pre    = ch_key[31:0];
                    rec.out_post   = ch_key[63:32];
                    rec.out_weight = ch_w;
                    emit           = 1'b1;
                end
            end
        end
        if (emit)
        begin
            if (rec_total != 32'hFFFF_FFFF)
                rec_total++;
            rec.kind = KIND_RECORD;
            expected_rsp.push_back(rec);
        end
        need_b = !(bh_valid || base_done);
        need_c = !(ch_valid || chg_done);
        if (need_b && need_c)
            st.need = NEED_BOTH;
        else if (need_b)
            st.need = NEED_BASE;
        else if (need_c)
            st.need = NEED_CHANGE;
        else
            st.need = NEED_DONE;
        st.kind  = KIND_STATUS;
        st.total = rec_total;
        st.last  = 1'b1;
        expected_rsp.push_back(st);
    endfunction

    function automatic req_t mk_req(logic [1:0] t, logic [31:0] post, logic [31:0] pre,
                                    logic [15:0] w, logic [31:0] cnt);
        req_t r;
        r.req_type  = t;
        r.post_id   = post;
        r.pre_id    = pre;
        r.weight    = w;
        r.hit_count = cnt;
        return r;
    endfunction

    function automatic req_t random_req();
        return mk_req(2'($urandom_range(3)), $urandom, $urandom, 16'($urandom), $urandom);
    endfunction

    function automatic logic [15:0] pick_weight();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_count();
        case ($urandom_range(7))
            0:       return $urandom_range(0, 2000);
            1:       return cfg_min_count;
            2:       return cfg_min_count - 32'd1;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'h8000_0000 | $urandom;
            5:       return $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] key_step();
        if ($urandom_range(9) != 0)
            return 64'($urandom_range(1, 4));
        return {24'd0, 8'($urandom), 32'($urandom)};
    endfunction

    // Mostly well-formed sorted traffic for whichever stream is wanted; the rest is
    // aimed at a stream whose head is pending, so the block ignores it. In strict mode
    // a zero-weight change only ever meets a base record with the same key.
    function automatic req_t next_merge_item();
        req_t        r;
        logic [63:0] k;
        logic        want_base;
        r = random_req();
        if ((bh_valid || ch_valid) && $urandom_range(99) < 15)
        begin
            if (bh_valid)
                r.req_type = $urandom_range(1) ? REQ_BASE : REQ_END_BASE;
            else
                r.req_type = $urandom_range(1) ? REQ_CHANGE : REQ_END_CHG;
            return r;
        end
        want_base = bh_valid ? 1'b0 : (ch_valid ? 1'b1 : 1'($urandom_range(1)));
        if ($urandom_range(99) < 3)
        begin
            if (want_base)
                base_cursor = {$urandom, $urandom};
            else
                chg_cursor = {$urandom, $urandom};
        end
        if (want_base)
        begin
            base_cursor += key_step();
            k = base_cursor;
            if (cfg_strict && ch_valid && ch_w == 16'd0)
                k = ch_key;
            r.req_type  = REQ_BASE;
            r.weight    = pick_weight();
            r.hit_count = pick_count();
        end
        else
        begin
            if (bh_valid && $urandom_range(99) < 35)
                k = bh_key;
            else
            begin
                chg_cursor += key_step();
                k = chg_cursor;
            end
            r.req_type = REQ_CHANGE;
            r.weight   = ($urandom_range(99) < 15) ? 16'h0000 : pick_weight();
            if (cfg_strict && r.weight == 16'sd0 && !(bh_valid && k == bh_key))
                r.weight = 16'sd1;
        end
        {r.post_id, r.pre_id} = k;
        return r;
    endfunction

    task automatic send_req(input req_t r);
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        merge_step(r);
        if ($urandom_range(99) < gap_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < gap_pct);
        end
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] min_cnt, input logic strict,
                              input logic use_cnt);
        wait_drained();
        wr_en    <= 1'b1;
        wr_index <= CFG_MIN_COUNT;
        wr_data  <= min_cnt;
        @(posedge clk);
        wr_index <= CFG_STRICT;
        wr_data  <= {31'd0, strict};
        @(posedge clk);
        wr_index <= CFG_USE_COUNTS;
        wr_data  <= {31'd0, use_cnt};
        @(posedge clk);
        wr_en          <= 1'b0;
        cfg_min_count  = min_cnt;
        cfg_strict     = strict;
        cfg_use_counts = use_cnt;
    endtask

    task automatic test_directed_cases();
        gap_pct   = 0;
        stall_pct = 0;
        send_req(mk_req(REQ_BASE, 32'd0, 32'd0, 16'h8000, 32'd0));
        send_req(mk_req(REQ_BASE, 32'd123, 32'd456, 16'h0001, 32'd1));
        send_req(mk_req(REQ_END_BASE, 32'd0, 32'd0, 16'h0000, 32'd0));
        send_req(mk_req(REQ_CHANGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h7FFF, 32'd0));
        send_req(mk_req(REQ_CHANGE, 32'd1, 32'd1, 16'h0001, 32'd0));
        send_req(mk_req(REQ_END_CHG, 32'd0, 32'd0, 16'h0000, 32'd0));
        send_req(mk_req(REQ_BASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0001, 32'hFFFF_FFFF));
        send_req(mk_req(REQ_CHANGE, 32'd5, 32'd7, 16'h0000, 32'd0));
        send_req(mk_req(REQ_BASE, 32'd5, 32'd7, 16'hFFFF, 32'd3));
        send_req(mk_req(REQ_CHANGE, 32'd3, 32'hFFFF_FFFF, 16'h0000, 32'd0));
        send_req(mk_req(REQ_BASE, 32'd4, 32'd0, 16'h1234, 32'd10));
        send_req(mk_req(REQ_CHANGE, 32'd4, 32'd0, 16'h8000, 32'd0));
        send_req(mk_req(REQ_BASE, 32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF, 32'h8000_0000));
        send_req(mk_req(REQ_CHANGE, 32'hFFFF_FFFF, 32'd0, 16'h5555, 32'd0));
        set_config(32'h8000_0000, 1'b0, 1'b1);
        send_req(mk_req(REQ_BASE, 32'hFFFF_FFFF, 32'd1, 16'hFFFB, 32'h8000_0001));
        send_req(mk_req(REQ_CHANGE, 32'hFFFF_FFFF, 32'd2, 16'hAAAA, 32'd0));
        send_req(mk_req(REQ_BASE, 32'hFFFF_FFFF, 32'd1, 16'h0064, 32'h7FFF_FFFF));
        send_req(mk_req(REQ_BASE, 32'd0, 32'd0, 16'h8000, 32'hFFFF_FFFF));
        send_req(mk_req(REQ_BASE, 32'd0, 32'd1, 16'h0005, 32'hFFFF_FFFF));
        send_req(mk_req(REQ_BASE, 32'd0, 32'd2, 16'h8000, 32'h8000_0000));
        wait_drained();
    endtask

    task automatic test_random_merge(input int n_items, input int gap, input int stall,
                                     input logic [31:0] min_cnt, input logic strict,
                                     input logic use_cnt);
        set_config(min_cnt, strict, use_cnt);
        gap_pct   = gap;
        stall_pct = stall;
        repeat (n_items) send_req(next_merge_item());
        wait_drained();
    endtask

    // The receiver holds off long enough for the output queue to fill and stall input.
    task automatic test_output_backpressure();
        gap_pct      = 0;
        stall_pct    = 0;
        rsp_hold_len = 300;
        repeat (80) send_req(next_merge_item());
        wait_drained();
    endtask

    // Ends the base stream, runs the change stream alone, then trips the strict check,
    // after which every transaction yields an error item.
    task automatic test_stream_end_and_strict_error();
        req_t r;
        set_config(32'd50, 1'b0, 1'b1);
        gap_pct   = 27;
        stall_pct = 27;
        if (bh_valid)
            send_req(mk_req(REQ_CHANGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0101, 32'd0));
        send_req(mk_req(REQ_END_BASE, 32'd0, 32'd0, 16'h0000, 32'd0));
        send_req(mk_req(REQ_END_BASE, 32'd0, 32'd0, 16'h0000, 32'd0));
        r          = random_req();
        r.req_type = REQ_BASE;
        send_req(r);
        repeat (40)
        begin
            r = random_req();
            if ($urandom_range(3) != 0)
            begin
                r.req_type = REQ_CHANGE;
                if ($urandom_range(4) == 0)
                    r.weight = 16'sd0;
            end
            else
                r.req_type = $urandom_range(1) ? REQ_BASE : REQ_END_BASE;
            send_req(r);
        end
        set_config(32'd50, 1'b1, 1'b1);
        send_req(mk_req(REQ_CHANGE, 32'd9, 32'd9, 16'h0000, 32'd0));
        repeat (10) send_req(random_req());
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        if (rsp_hold_len > 0)
        begin
            hold_left    = rsp_hold_len;
            rsp_hold_len = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsp.size() == 0)
            begin
                $error("result transaction with nothing expected: %p", rsp);
                err_count++;
            end
            else
            begin
                want = expected_rsp.pop_front();
                check_field("kind", 32'(want.kind), 32'(rsp.kind));
                check_field("out_pre", want.out_pre, rsp.out_pre);
                check_field("out_post", want.out_post, rsp.out_post);
                check_field("out_weight", 32'(want.out_weight), 32'(rsp.out_weight));
                check_field("need", 32'(want.need), 32'(rsp.need));
                check_field("total", want.total, rsp.total);
                check_field("last", 32'(want.last), 32'(rsp.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_random_merge(430, 0, 0, 32'd0, 1'b0, 1'b0);
        test_random_merge(430, 51, 0, 32'd1000, 1'b0, 1'b1);
        test_random_merge(430, 0, 51, 32'hFFFF_FFFF, 1'b1, 1'b1);
        test_random_merge(430, 27, 27, 32'd0, 1'b1, 1'b0);
        test_output_backpressure();
        test_stream_end_and_strict_error();
        wait_drained();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/srdm_pkg.sv
rtl/srdm_front.sv
rtl/srdm_queue.sv
rtl/srdm_back.sv
rtl/sorted_record_delta_merge.sv
tb/sv/tb_sorted_record_delta_merge.sv
